### design/ucca_pkg.sv
`default_nettype none

package ucca_pkg;

   // Request selector codes carried in req_tuser.
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_CCA   = 2'd2;

   // Event codes carried in rsp_tuser.
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_CCA_REQ = 2'd1;
   localparam logic [1:0] EV_IDLE    = 2'd2;
   localparam logic [1:0] EV_FAIL    = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MIN_EXPONENT = 3'd0;
   localparam logic [2:0] CSR_MAX_EXPONENT = 3'd1;
   localparam logic [2:0] CSR_MAX_BACKOFFS = 3'd2;
   localparam logic [2:0] CSR_UNIT_TICKS   = 3'd3;
   localparam logic [2:0] CSR_MAX_ROUNDS   = 3'd4;

   // Configuration reset values.
   localparam logic [3:0]  RST_MIN_EXPONENT = 4'd1;
   localparam logic [3:0]  RST_MAX_EXPONENT = 4'd3;
   localparam logic [3:0]  RST_MAX_BACKOFFS = 4'd10;
   localparam logic [15:0] RST_UNIT_TICKS   = 16'd1;
   localparam logic [3:0]  RST_MAX_ROUNDS   = 4'd3;

   // Default hard ceiling on the backoff exponent.
   localparam int MAX_EXPONENT_DEFAULT = 8;

   typedef struct packed {
      logic [3:0]  min_exponent;
      logic [3:0]  max_exponent;
      logic [3:0]  max_backoffs;
      logic [15:0] unit_ticks;
      logic [3:0]  max_rounds;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       cca_clear;
      logic [7:0] random_bits;
   } req_item_type;

   typedef struct packed {
      logic [1:0] event_code;
      logic [3:0] busy_count;
      logic [3:0] exponent_now;
      logic       in_access;
   } rsp_item_type;

endpackage

`default_nettype wire

### design/ucca_engine.sv
`default_nettype none

module ucca_engine
   import ucca_pkg::*;
#(
   parameter int MAX_EXPONENT = MAX_EXPONENT_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         step,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   logic        active_ff, active_in;
   logic        awaiting_ff, awaiting_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  exponent_ff, exponent_in;
   logic [23:0] countdown_ff, countdown_in;
   logic [3:0]  round_ff, round_in;

   logic [1:0]  event_code;
   logic        do_load;
   logic [3:0]  load_exp;
   logic [7:0]  mask;
   logic [7:0]  periods;
   logic [23:0] product;
   logic        load_zero;
   logic [4:0]  exp_up;
   logic [4:0]  exp_capped;
   logic [3:0]  exp_next;
   logic [4:0]  busy_next;

   function automatic logic [3:0] clamp_exp(input logic [4:0] e);
      logic [3:0] r;
      if (32'(e) > 32'(MAX_EXPONENT)) begin
         r = 4'(MAX_EXPONENT);
      end else begin
         r = e[3:0];
      end
      return r;
   endfunction

   always_comb begin
      active_in    = active_ff;
      awaiting_in  = awaiting_ff;
      count_in     = count_ff;
      exponent_in  = exponent_ff;
      countdown_in = countdown_ff;
      round_in     = round_ff;
      event_code   = EV_NONE;
      do_load      = 1'b0;
      load_exp     = exponent_ff;

      exp_up     = 5'(exponent_ff) + 5'd1;
      exp_capped = (exp_up > {1'b0, cfg.max_exponent}) ? {1'b0, cfg.max_exponent} : exp_up;
      exp_next   = clamp_exp(exp_capped);
      busy_next  = 5'(count_ff) + 5'd1;

      if (step) begin
         case (item.req_type)
            REQ_START: begin
               active_in   = 1'b1;
               round_in    = 4'd0;
               count_in    = 4'd0;
               load_exp    = clamp_exp({1'b0, cfg.min_exponent});
               exponent_in = load_exp;
               do_load     = 1'b1;
            end
            REQ_TICK: begin
               if (active_ff && !awaiting_ff && (countdown_ff != 24'd0)) begin
                  countdown_in = countdown_ff - 24'd1;
                  if (countdown_ff == 24'd1) begin
                     awaiting_in = 1'b1;
                     event_code  = EV_CCA_REQ;
                  end
               end
            end
            REQ_CCA: begin
               if (active_ff && awaiting_ff) begin
                  awaiting_in = 1'b0;
                  if (item.cca_clear) begin
                     active_in  = 1'b0;
                     round_in   = 4'd0;
                     event_code = EV_IDLE;
                  end else begin
                     exponent_in = exp_next;
                     count_in    = busy_next[4] ? 4'd15 : busy_next[3:0];
                     if (busy_next > {1'b0, cfg.max_backoffs}) begin
                        if (round_ff < cfg.max_rounds) begin
                           // The round has failed: start a fresh one.
                           round_in    = round_ff + 4'd1;
                           count_in    = 4'd0;
                           load_exp    = clamp_exp({1'b0, cfg.min_exponent});
                           exponent_in = load_exp;
                           do_load     = 1'b1;
                        end else begin
                           active_in    = 1'b0;
                           round_in     = 4'd0;
                           countdown_in = 24'd0;
                           event_code   = EV_FAIL;
                        end
                     end else begin
                        load_exp = exp_next;
                        do_load  = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // One shared backoff loader: draw masked to the exponent, times the unit.
      mask      = (load_exp >= 4'd8) ? 8'hFF : 8'((9'd1 << load_exp[2:0]) - 9'd1);
      periods   = item.random_bits & mask;
      product   = 24'(periods) * 24'(cfg.unit_ticks);
      load_zero = (periods == 8'd0) || (cfg.unit_ticks == 16'd0);

      if (do_load) begin
         countdown_in = product;
         awaiting_in  = load_zero;
         event_code   = load_zero ? EV_CCA_REQ : EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         awaiting_ff  <= 1'b0;
         count_ff     <= 4'd0;
         exponent_ff  <= 4'd0;
         countdown_ff <= 24'd0;
         round_ff     <= 4'd0;
      end else begin
         active_ff    <= active_in;
         awaiting_ff  <= awaiting_in;
         count_ff     <= count_in;
         exponent_ff  <= exponent_in;
         countdown_ff <= countdown_in;
         round_ff     <= round_in;
      end
   end

   assign result.event_code   = event_code;
   assign result.busy_count   = count_in;
   assign result.exponent_now = exponent_in;
   assign result.in_access    = active_in;

   a_await_needs_active: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> active_ff)
      else $error("waiting for a CCA result outside an access");

   a_exp_ceiling: assert property (@(posedge clock) disable iff (reset)
      32'(exponent_ff) <= 32'(MAX_EXPONENT))
      else $error("backoff exponent above its hard ceiling");

   a_tick_while_waiting: assert property (@(posedge clock) disable iff (reset)
      step && (item.req_type == REQ_TICK) && awaiting_ff |=> $stable(countdown_ff))
      else $error("countdown moved while waiting for a CCA result");

endmodule

`default_nettype wire

### design/ucca_rsp_buf.sv
`default_nettype none

module ucca_rsp_buf
   import ucca_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire rsp_item_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_data
);

   logic         out_valid_ff;
   logic         skid_valid_ff;
   rsp_item_type out_data_ff;
   rsp_item_type skid_data_ff;
   logic         push;
   logic         pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff <= in_data;
         end else begin
            skid_data_ff <= in_data;
         end
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with an empty output register");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry did not move to the output register");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push && !out_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("transfer into an empty buffer did not reach the output");

endmodule

`default_nettype wire

### design/unslotted_csma_ca_backoff_top.sv
`default_nettype none

// Unslotted CSMA/CA backoff engine. A start request opens a channel access,
// tick requests count down a random backoff of (random_bits masked to the
// exponent) times unit_ticks, and when the countdown runs out the block asks
// for a clear channel assessment (event 1). A CCA result that reports a clear
// channel ends the access with event 2; a busy one raises the exponent and
// draws a new backoff, and once too many busy results pile up the round is
// restarted, up to max_rounds times, before access failure (event 3) is
// reported. Every accepted request yields exactly one response, in order,
// carrying the event code and the busy count, exponent and activity flag as
// they stand after that request. The block takes one request per clock cycle
// while req_tready is high, and each response is registered at the edge of
// its request transfer, so with an empty buffer rsp_tvalid rises in the
// following cycle; the state update for a request is a single pass through an
// 8 by 16 bit multiply and a handful of small compares. A two-entry output
// buffer lets requests keep flowing while one response waits, and req_tready
// falls only when both entries are full. Configuration writes are always
// accepted and should be made while the block is idle.

module unslotted_csma_ca_backoff_top
   import ucca_pkg::*;
#(
   parameter int MAX_EXPONENT = MAX_EXPONENT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [0] cca_clear, [8:1] random_bits, rest zero
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type

   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [3:0] busy_count, [7:4] exponent_now,
                                         // [8] in_access, rest zero
   output logic [1:0]       rsp_tuser,   // [1:0] event_code

   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type      cfg_ff;
   req_item_type item;
   rsp_item_type step_result;
   rsp_item_type out_item;
   logic         step;
   logic         buf_ready;

   // Configuration registers. Writes to an index beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_exponent <= RST_MIN_EXPONENT;
         cfg_ff.max_exponent <= RST_MAX_EXPONENT;
         cfg_ff.max_backoffs <= RST_MAX_BACKOFFS;
         cfg_ff.unit_ticks   <= RST_UNIT_TICKS;
         cfg_ff.max_rounds   <= RST_MAX_ROUNDS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_EXPONENT: cfg_ff.min_exponent <= csr_data[3:0];
            CSR_MAX_EXPONENT: cfg_ff.max_exponent <= csr_data[3:0];
            CSR_MAX_BACKOFFS: cfg_ff.max_backoffs <= csr_data[3:0];
            CSR_UNIT_TICKS:   cfg_ff.unit_ticks   <= csr_data;
            CSR_MAX_ROUNDS:   cfg_ff.max_rounds   <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Unpack the request fields.
   assign item.req_type    = req_tuser;
   assign item.cca_clear   = req_tdata[0];
   assign item.random_bits = req_tdata[8:1];

   // A request transfer steps the engine once.
   assign req_tready = buf_ready;
   assign step       = req_tvalid && buf_ready;

   ucca_engine #(
      .MAX_EXPONENT(MAX_EXPONENT)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (step),
      .item   (item),
      .result (step_result)
   );

   // The response buffer holds the result of each step until it is taken.
   ucca_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step),
      .in_ready  (buf_ready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_item)
   );

   assign rsp_tuser = out_item.event_code;
   assign rsp_tdata = {7'd0, out_item.in_access, out_item.exponent_now, out_item.busy_count};

endmodule

`default_nettype wire

### sim/tb_unslotted_csma_ca_backoff_top.sv
`timescale 1ns / 1ps

module tb_unslotted_csma_ca_backoff_top;
   import ucca_pkg::*;

   // The request selector value that carries no meaning; the block must ignore it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // A loaded countdown longer than this is cut short by a restart, so that
   // the stimulus keeps reaching CCA results instead of ticking for ages.
   localparam int TICK_CAP      = 400;
   // Cycles without any transfer on any channel before the run is abandoned.
   localparam int IDLE_LIMIT    = 2000;
   // Length of the one long response hold-off that fills the output buffer.
   localparam int HOLD_CYCLES   = 64;
   // Quiet cycles after the last response before registers are rewritten.
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS   = 30;

   typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_TOGGLE} ready_mode_type;

   // Tracks the channel access state as the block should hold it. One copy
   // checks the responses; a second copy runs ahead of the request driver so
   // that the stimulus knows when a tick or a CCA result will be acted upon.
   class csma_tracker_type;
      cfg_type        cfg;
      bit             active;
      bit             awaiting;
      logic [3:0]     busy;
      logic [3:0]     expo;
      logic [3:0]     rounds;
      logic [23:0]    countdown;
      rsp_item_type   pending_events[$];
      int             checked;
      int             errors;

      function new();
         cfg = '{RST_MIN_EXPONENT, RST_MAX_EXPONENT, RST_MAX_BACKOFFS,
                 RST_UNIT_TICKS, RST_MAX_ROUNDS};
         active    = 1'b0;
         awaiting  = 1'b0;
         busy      = '0;
         expo      = '0;
         rounds    = '0;
         countdown = '0;
         checked   = 0;
         errors    = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [15:0] data);
         case (index)
            CSR_MIN_EXPONENT: cfg.min_exponent = data[3:0];
            CSR_MAX_EXPONENT: cfg.max_exponent = data[3:0];
            CSR_MAX_BACKOFFS: cfg.max_backoffs = data[3:0];
            CSR_UNIT_TICKS:   cfg.unit_ticks   = data;
            CSR_MAX_ROUNDS:   cfg.max_rounds   = data[3:0];
            default: ;
         endcase
      endfunction

      // Every exponent is held at the block's hard ceiling as well.
      function logic [3:0] clamp_ceiling(int unsigned e);
         return (e > MAX_EXPONENT_DEFAULT) ? 4'(MAX_EXPONENT_DEFAULT) : 4'(e);
      endfunction

      // Loads a fresh backoff; an empty backoff asks for the CCA at once.
      function logic [1:0] load_countdown(logic [7:0] draw);
         logic [15:0] mask;
         logic [7:0]  periods;
         logic [31:0] product;
         mask      = (16'd1 << expo) - 16'd1;
         periods   = draw & mask[7:0];
         product   = periods * cfg.unit_ticks;
         countdown = product[23:0];
         awaiting  = (countdown == 24'd0);
         return awaiting ? EV_CCA_REQ : EV_NONE;
      endfunction

      function logic [1:0] open_round(logic [7:0] draw);
         busy = '0;
         expo = clamp_ceiling(32'(cfg.min_exponent));
         return load_countdown(draw);
      endfunction

      function rsp_item_type advance(req_item_type rq);
         rsp_item_type r;
         logic [1:0]   ev;
         int unsigned  next_exp;
         int unsigned  next_busy;
         ev = EV_NONE;
         case (rq.req_type)
            REQ_START: begin
               active = 1'b1;
               rounds = '0;
               ev     = open_round(rq.random_bits);
            end
            REQ_TICK: begin
               if (active && !awaiting && countdown != 24'd0) begin
                  countdown = countdown - 24'd1;
                  if (countdown == 24'd0) begin
                     awaiting = 1'b1;
                     ev       = EV_CCA_REQ;
                  end
               end
            end
            REQ_CCA: begin
               if (active && awaiting) begin
                  awaiting = 1'b0;
                  if (rq.cca_clear) begin
                     active = 1'b0;
                     rounds = '0;
                     ev     = EV_IDLE;
                  end else begin
                     next_exp  = expo + 1;
                     next_busy = busy + 1;
                     if (next_exp > cfg.max_exponent) next_exp = 32'(cfg.max_exponent);
                     expo = clamp_ceiling(next_exp);
                     // The reported count saturates, the limit test does not.
                     busy = (next_busy > 15) ? 4'd15 : 4'(next_busy);
                     if (next_busy > cfg.max_backoffs) begin
                        if (rounds < cfg.max_rounds) begin
                           rounds = rounds + 4'd1;
                           ev     = open_round(rq.random_bits);
                        end else begin
                           active    = 1'b0;
                           rounds    = '0;
                           countdown = '0;
                           ev        = EV_FAIL;
                        end
                     end else begin
                        ev = load_countdown(rq.random_bits);
                     end
                  end
               end
            end
            default: ;
         endcase
         r.event_code   = ev;
         r.busy_count   = busy;
         r.exponent_now = expo;
         r.in_access    = active;
         return r;
      endfunction

      function void note_request(req_item_type rq);
         pending_events.push_back(advance(rq));
      endfunction

      function void flag(string field, int unsigned want, int unsigned got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (pending_events.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with none expected, actual event %0d",
                        $time, got.event_code);
            return;
         end
         want = pending_events.pop_front();
         checked++;
         if (got.event_code !== want.event_code)
            flag("event_code", 32'(want.event_code), 32'(got.event_code));
         if (got.busy_count !== want.busy_count)
            flag("busy_count", 32'(want.busy_count), 32'(got.busy_count));
         if (got.exponent_now !== want.exponent_now)
            flag("exponent_now", 32'(want.exponent_now), 32'(got.exponent_now));
         if (got.in_access !== want.in_access)
            flag("in_access", 32'(want.in_access), 32'(got.in_access));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;   // [0] cca_clear, [8:1] random_bits, rest zero
   logic [1:0]  req_tuser  = '0;   // [1:0] req_type
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;         // [3:0] busy_count, [7:4] exponent_now, [8] in_access
   wire  [1:0]  rsp_tuser;         // [1:0] event_code
   wire         csr_ready;

   csma_tracker_type expected_events;
   csma_tracker_type lookahead;

   int burst_left          = 0;
   int requests_sent       = 0;
   int settings_used       = 1;
   int input_stall_cycles  = 0;
   int event_tally[4]      = '{0, 0, 0, 0};
   bit hold_off_due        = 1'b0;

   wire any_transfer = (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                       (csr_valid && csr_ready);

   always #1 clock = ~clock;

   unslotted_csma_ca_backoff_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Every response transfer is checked against the oldest expectation. The
   // outputs are read just after the edge, before any register has moved.
   always @(posedge clock) begin : response_monitor
      rsp_item_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.event_code   = rsp_tuser;
            got.busy_count   = rsp_tdata[3:0];
            got.exponent_now = rsp_tdata[7:4];
            got.in_access    = rsp_tdata[8];
            expected_events.check_response(got);
            event_tally[rsp_tuser]++;
         end
         if (req_tvalid && !req_tready) input_stall_cycles++;
      end
   end

   // The receiver moves between stall patterns of random length, one of which
   // never stalls. Once, on request, it holds off long enough for the block's
   // output buffer to fill and its request side to back up.
   initial begin : response_sink
      ready_mode_type mode;
      int             mode_left;
      bit             ready_now;
      mode      = READY_ALWAYS;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: ready_now = 1'b1;
               READY_HALF:   ready_now = 1'($urandom_range(0, 1));
               READY_SPARSE: ready_now = ($urandom_range(0, 3) == 0);
               default:      ready_now = ~rsp_tready;
            endcase
            rsp_tready <= ready_now;
         end
      end
   end

   // Ends the run if no transfer of any kind happens for too long.
   initial begin : watchdog
      int quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (any_transfer) quiet = 0;
         else quiet++;
      end
      $display("Run stalled: no transfer for %0d cycles.", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Offers one request. The driver works in bursts: at the end of a burst
   // tvalid drops for a random pause, otherwise it stays high from one transfer
   // to the next and only the data changes.
   task automatic offer(req_item_type rq);
      void'(lookahead.advance(rq));
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, rq.random_bits, rq.cca_clear};
      req_tuser  <= rq.req_type;
      do @(posedge clock); while (!req_tready);
      expected_events.note_request(rq);
      burst_left--;
      requests_sent++;
   endtask

   task automatic offer_fields(logic [1:0] kind, logic clear, logic [7:0] draw);
      req_item_type rq;
      rq.req_type    = kind;
      rq.cca_clear   = clear;
      rq.random_bits = draw;
      offer(rq);
   endtask

   // Stops offering and lets every outstanding response drain, so that the
   // block is idle afterwards.
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_events.pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high between back-to-back writes and dropped once the
   // last one has gone through.
   task automatic write_register(logic [2:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      expected_events.write_register(index, data);
      lookahead.write_register(index, data);
   endtask

   task automatic configure(cfg_type c);
      write_register(CSR_MIN_EXPONENT, {12'b0, c.min_exponent});
      write_register(CSR_MAX_EXPONENT, {12'b0, c.max_exponent});
      write_register(CSR_MAX_BACKOFFS, {12'b0, c.max_backoffs});
      write_register(CSR_UNIT_TICKS, c.unit_ticks);
      write_register(CSR_MAX_ROUNDS, {12'b0, c.max_rounds});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic cfg_type make_cfg(logic [3:0] min_e, logic [3:0] max_e,
                                        logic [3:0] backoffs, logic [15:0] unit,
                                        logic [3:0] rounds);
      cfg_type c;
      c.min_exponent = min_e;
      c.max_exponent = max_e;
      c.max_backoffs = backoffs;
      c.unit_ticks   = unit;
      c.max_rounds   = rounds;
      return c;
   endfunction

   // Draws are kept mostly small so that countdowns stay short; with a long
   // unit period the masked part of the draw is left empty.
   function automatic logic [7:0] pick_draw();
      if (lookahead.cfg.unit_ticks > 16'd8) return 8'h00;
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 7));
   endfunction

   // Most requests follow a well-formed access: a start when idle, ticks
   // while counting down, a CCA result once one has been asked for. The rest
   // are noise: stray ticks and CCA results, restarts and the unused selector.
   task automatic random_phase(int count, int clear_pct, int noise_pct);
      req_item_type rq;
      repeat (count) begin
         rq.cca_clear   = 1'($urandom_range(0, 1));
         rq.random_bits = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < noise_pct) begin
            rq.req_type = 2'($urandom_range(0, 3));
         end else if (!lookahead.active) begin
            rq.req_type    = REQ_START;
            rq.random_bits = pick_draw();
         end else if (lookahead.awaiting) begin
            rq.req_type    = REQ_CCA;
            rq.cca_clear   = ($urandom_range(0, 99) < clear_pct);
            rq.random_bits = pick_draw();
         end else if (lookahead.countdown > TICK_CAP) begin
            rq.req_type    = REQ_START;
            rq.random_bits = 8'h00;
         end else begin
            rq.req_type = REQ_TICK;
         end
         offer(rq);
      end
      finish_phase();
   endtask

   initial begin : stimulus
      expected_events = new();
      lookahead       = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: requests that must be ignored,
      // a zero backoff, a start during an access, the exponent reaching its
      // ceiling, and a countdown run out by ticks.
      offer_fields(REQ_CCA, 1'b1, 8'hFF);
      offer_fields(REQ_TICK, 1'b0, 8'h00);
      offer_fields(REQ_UNUSED, 1'b1, 8'hFF);
      offer_fields(REQ_START, 1'b0, 8'h00);
      offer_fields(REQ_TICK, 1'b1, 8'hFF);
      offer_fields(REQ_CCA, 1'b0, 8'h03);
      offer_fields(REQ_CCA, 1'b1, 8'h00);
      offer_fields(REQ_UNUSED, 1'b0, 8'h00);
      offer_fields(REQ_TICK, 1'b0, 8'h00);
      offer_fields(REQ_TICK, 1'b0, 8'h00);
      offer_fields(REQ_TICK, 1'b0, 8'h00);
      offer_fields(REQ_CCA, 1'b1, 8'h00);
      offer_fields(REQ_START, 1'b0, 8'hFF);
      offer_fields(REQ_START, 1'b1, 8'hFE);
      offer_fields(REQ_CCA, 1'b0, 8'h00);
      offer_fields(REQ_CCA, 1'b0, 8'h00);
      offer_fields(REQ_CCA, 1'b0, 8'h00);
      offer_fields(REQ_CCA, 1'b1, 8'hAA);
      offer_fields(REQ_START, 1'b0, 8'h55);
      offer_fields(REQ_TICK, 1'b0, 8'h00);
      offer_fields(REQ_CCA, 1'b1, 8'h00);
      finish_phase();

      // Every limit at zero: each busy result fails the access outright.
      configure(make_cfg(4'd0, 4'd0, 4'd0, 16'd0, 4'd0));
      random_phase(120, 25, 8);

      // Every limit at its top with empty backoffs and a channel that never
      // clears, so the full sixteen rounds of sixteen busy results run out.
      configure(make_cfg(4'd15, 4'd15, 4'd15, 16'd0, 4'd15));
      random_phase(300, 0, 0);

      // Longest unit period, and a start exponent above the ceiling.
      configure(make_cfg(4'd8, 4'd2, 4'd3, 16'hFFFF, 4'd1));
      random_phase(120, 20, 8);

      // The long response hold-off falls in this phase.
      configure(make_cfg(4'd2, 4'd5, 4'd4, 16'd1, 4'd2));
      hold_off_due = 1'b1;
      random_phase(350, 15, 8);

      configure(make_cfg(4'd1, 4'd8, 4'd6, 16'd3, 4'd3));
      random_phase(300, 15, 8);

      configure(make_cfg(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 16'($urandom_range(0, 6)),
                         4'($urandom_range(0, 7))));
      random_phase(300, 15, 8);

      $display("Covered %0d requests under %0d register settings: %0d CCA requests,",
               requests_sent, settings_used, event_tally[EV_CCA_REQ]);
      $display("%0d idle reports, %0d access failures; request side held off %0d cycles.",
               event_tally[EV_IDLE], event_tally[EV_FAIL], input_stall_cycles);
      if (expected_events.errors == 0 && expected_events.pending_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
